### rtl/particle_pool_update_core_defines.svh
// Assertion helpers for the RTL, included by ppu_back.
`ifndef PARTICLE_POOL_UPDATE_CORE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ppu_pkg.sv
`timescale 1ns / 1ps
package ppu_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int FIFO_DEPTH_DEF = 2;
    localparam int RATIO_W        = 17;
    localparam int DIV_STEPS      = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic OP_EMIT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VEL_VAR_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_VAR_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_VAR_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SPREAD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_FINAL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIFE_SPAN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_RGBA = 3'd7;

    typedef struct packed {
        logic [30:0]        vel_var_x;
        logic [30:0]        vel_var_y;
        logic [30:0]        vel_var_z;
        logic signed [15:0] size_start;
        logic [14:0]        size_spread;
        logic signed [15:0] size_final;
        logic [31:0]        life_span;
        logic [31:0]        colour_rgba;
    } t_cfg;

    typedef struct packed {
        logic               is_tick;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] rand_x;
        logic signed [15:0] rand_y;
        logic signed [15:0] rand_z;
        logic signed [15:0] rand_size;
        logic [15:0]        delta_time;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] out_size;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
        logic               last;
    } t_res;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

endpackage

### rtl/particle_pool_update_core.sv
`timescale 1ns / 1ps
// Particle pool update core. Emit words write one pool slot and step the ring
// pointer down; they give no result. A tick word walks every slot: an empty
// slot is only scanned, an expired one is cleared, and a live one waits on the
// life-ratio divider that retires one quotient bit per cycle and is shared by
// all slots. Input and result sides are short queues, and the last result of a
// tick is flagged once the walk has ended, so it leaves one word behind the
// others. Registers must be written only while the core is idle; the core
// itself does not enforce this.
module particle_pool_update_core #(
    parameter int POOL_DEPTH = ppu_pkg::POOL_DEPTH_DEF,
    parameter int FIFO_DEPTH = ppu_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_opcode,
    input  logic signed [31:0]               i_pos_x,
    input  logic signed [31:0]               i_pos_y,
    input  logic signed [31:0]               i_pos_z,
    input  logic signed [31:0]               i_vel_x,
    input  logic signed [31:0]               i_vel_y,
    input  logic signed [31:0]               i_vel_z,
    input  logic signed [15:0]               i_rand_x,
    input  logic signed [15:0]               i_rand_y,
    input  logic signed [15:0]               i_rand_z,
    input  logic signed [15:0]               i_rand_size,
    input  logic [15:0]                      i_delta_time,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [31:0]               o_out_x,
    output logic signed [31:0]               o_out_y,
    output logic signed [31:0]               o_out_z,
    output logic signed [15:0]               o_out_size,
    output logic [7:0]                       o_out_red,
    output logic [7:0]                       o_out_green,
    output logic [7:0]                       o_out_blue,
    output logic [7:0]                       o_out_alpha,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ppu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ppu_pkg::*;

    t_cfg     r_cfg;
    t_cmd     in_cmd, head_cmd;
    t_res     back_res, out_res;
    t_div_req div_req;
    logic     cmd_empty, cmd_pop, res_push, res_full, div_done;
    logic [RATIO_W-1:0] div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vel_var_x   <= '0;
            r_cfg.vel_var_y   <= '0;
            r_cfg.vel_var_z   <= '0;
            r_cfg.size_start  <= 16'sd256;
            r_cfg.size_spread <= '0;
            r_cfg.size_final  <= '0;
            r_cfg.life_span   <= 32'd65536;
            r_cfg.colour_rgba <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VEL_VAR_X:   r_cfg.vel_var_x   <= i_cfg_data[30:0];
                REG_VEL_VAR_Y:   r_cfg.vel_var_y   <= i_cfg_data[30:0];
                REG_VEL_VAR_Z:   r_cfg.vel_var_z   <= i_cfg_data[30:0];
                REG_SIZE_START:  r_cfg.size_start  <= i_cfg_data[15:0];
                REG_SIZE_SPREAD: r_cfg.size_spread <= i_cfg_data[14:0];
                REG_SIZE_FINAL:  r_cfg.size_final  <= i_cfg_data[15:0];
                REG_LIFE_SPAN:   r_cfg.life_span   <= i_cfg_data;
                REG_COLOUR_RGBA: r_cfg.colour_rgba <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the incoming word on the way into the command queue.
    always_comb begin
        in_cmd.is_tick    = (i_opcode == OP_TICK);
        in_cmd.pos_x      = i_pos_x;
        in_cmd.pos_y      = i_pos_y;
        in_cmd.pos_z      = i_pos_z;
        in_cmd.vel_x      = i_vel_x;
        in_cmd.vel_y      = i_vel_y;
        in_cmd.vel_z      = i_vel_z;
        in_cmd.rand_x     = i_rand_x;
        in_cmd.rand_y     = i_rand_y;
        in_cmd.rand_z     = i_rand_z;
        in_cmd.rand_size  = i_rand_size;
        in_cmd.delta_time = i_delta_time;
    end

    ppu_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (FIFO_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (in_cmd),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_rdata (head_cmd),
        .o_empty (cmd_empty)
    );

    ppu_back #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (head_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_div_req   (div_req),
        .i_div_done  (div_done),
        .i_div_q     (div_q)
    );

    ppu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    ppu_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (out_res),
        .o_empty (empty)
    );

    assign o_out_x     = out_res.out_x;
    assign o_out_y     = out_res.out_y;
    assign o_out_z     = out_res.out_z;
    assign o_out_size  = out_res.out_size;
    assign o_out_red   = out_res.out_red;
    assign o_out_green = out_res.out_green;
    assign o_out_blue  = out_res.out_blue;
    assign o_out_alpha = out_res.out_alpha;
    assign o_last      = out_res.last;
endmodule

### rtl/ppu_fifo.sv
`timescale 1ns / 1ps
module ppu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_en) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end
endmodule

### rtl/ppu_div.sv
`timescale 1ns / 1ps
module ppu_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ppu_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [ppu_pkg::RATIO_W-1:0] o_q
);
    import ppu_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        r_rem, r_dvs;
    logic [RATIO_W-1:0] r_q;
    logic [32:0]        trial;
    logic               ge, ge0;
    logic [31:0]        rem_step;

    // Dividend never exceeds divisor, so the top quotient bit is one compare.
    assign ge0      = (i_req.dividend >= i_req.divisor);
    assign trial    = {r_rem, 1'b0};
    assign ge       = (trial >= {1'b0, r_dvs});
    assign rem_step = ge ? 32'(trial - {1'b0, r_dvs}) : trial[31:0];
    assign o_done   = r_busy && (r_cnt == '0);
    assign o_q      = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
            r_rem <= ge0 ? i_req.dividend - i_req.divisor : i_req.dividend;
            r_q   <= {{(RATIO_W - 1){1'b0}}, ge0};
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= rem_step;
            r_q   <= {r_q[RATIO_W-2:0], ge};
        end
    end
endmodule

### rtl/ppu_back.sv
`timescale 1ns / 1ps
module ppu_back #(
    parameter int POOL_DEPTH = ppu_pkg::POOL_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppu_pkg::t_cfg               i_cfg,
    input  ppu_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    output ppu_pkg::t_res               o_res,
    output logic                        o_res_push,
    input  logic                        i_res_full,
    output ppu_pkg::t_div_req           o_div_req,
    input  logic                        i_div_done,
    input  logic [ppu_pkg::RATIO_W-1:0] i_div_q
);
    import ppu_pkg::*;
    `include "particle_pool_update_core_defines.svh"

    localparam int IW = $clog2(POOL_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EMUL  = 8'b0000_0010,
        S_EWR   = 8'b0000_0100,
        S_TSCAN = 8'b0000_1000,
        S_TLOAD = 8'b0001_0000,
        S_TDIV  = 8'b0010_0000,
        S_TFIN  = 8'b0100_0000,
        S_TEND  = 8'b1000_0000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    t_state r_state, n_state;
    logic [POOL_DEPTH-1:0] r_alive;
    logic [IW-1:0] r_slot, r_idx;
    t_cmd r_cmd;
    t_res r_hold, new_res;
    logic r_hold_v;

    logic [31:0] r_mem_px [POOL_DEPTH];
    logic [31:0] r_mem_py [POOL_DEPTH];
    logic [31:0] r_mem_pz [POOL_DEPTH];
    logic [31:0] r_mem_vx [POOL_DEPTH];
    logic [31:0] r_mem_vy [POOL_DEPTH];
    logic [31:0] r_mem_vz [POOL_DEPTH];
    logic [15:0] r_mem_bs [POOL_DEPTH];
    logic [15:0] r_mem_es [POOL_DEPTH];
    logic [31:0] r_mem_ll [POOL_DEPTH];
    logic [31:0] r_mem_lt [POOL_DEPTH];
    logic [31:0] r_mem_tn [POOL_DEPTH];

    logic signed [31:0] r_rd_px, r_rd_py, r_rd_pz, r_rd_vx, r_rd_vy, r_rd_vz;
    logic signed [15:0] r_rd_bs, r_rd_es;
    logic [31:0]        r_rd_ll, r_rd_lt, r_rd_tn;

    logic signed [47:0] r_pvx, r_pvy, r_pvz;
    logic signed [31:0] r_psz;
    logic signed [48:0] r_pmx, r_pmy, r_pmz;
    logic signed [34:0] r_psize;
    logic [24:0]        r_palpha;
    logic signed [31:0] r_nx, r_ny, r_nz;
    logic [31:0]        r_life;

    logic signed [47:0] sh_vx, sh_vy, sh_vz;
    logic signed [31:0] e_vx, e_vy, e_vz;
    logic signed [16:0] sh_sz;
    logic signed [17:0] sum_sz;
    logic signed [15:0] e_bs;
    logic signed [48:0] sh_mx, sh_my, sh_mz;
    logic signed [31:0] t_nx, t_ny, t_nz;
    logic [31:0]        n_life;
    logic signed [16:0] diff_sz;
    logic signed [18:0] out_sz;
    logic               last_idx, we_emit, we_tick;

    assign last_idx = (r_idx == IW'(POOL_DEPTH - 1));
    assign we_emit  = (r_state == S_EWR);
    assign we_tick  = (r_state == S_TFIN);

    // Emit: base plus variation times random, floored and saturated.
    always_comb begin
        sh_vx  = r_pvx >>> 15;
        sh_vy  = r_pvy >>> 15;
        sh_vz  = r_pvz >>> 15;
        e_vx   = sat32({{18{r_cmd.vel_x[31]}}, r_cmd.vel_x} + {{2{sh_vx[47]}}, sh_vx});
        e_vy   = sat32({{18{r_cmd.vel_y[31]}}, r_cmd.vel_y} + {{2{sh_vy[47]}}, sh_vy});
        e_vz   = sat32({{18{r_cmd.vel_z[31]}}, r_cmd.vel_z} + {{2{sh_vz[47]}}, sh_vz});
        sh_sz  = r_psz[31:15];
        sum_sz = {{2{i_cfg.size_start[15]}}, i_cfg.size_start} + {sh_sz[16], sh_sz};
        if (sum_sz > 18'sd32767) begin
            e_bs = 16'sh7FFF;
        end else if (sum_sz < -18'sd32768) begin
            e_bs = 16'sh8000;
        end else begin
            e_bs = sum_sz[15:0];
        end
    end

    // Tick: age, move, interpolate.
    always_comb begin
        n_life  = (r_rd_ll > {16'b0, r_cmd.delta_time}) ?
                  r_rd_ll - {16'b0, r_cmd.delta_time} : '0;
        sh_mx   = r_pmx >>> 16;
        sh_my   = r_pmy >>> 16;
        sh_mz   = r_pmz >>> 16;
        t_nx    = sat32({{18{r_rd_px[31]}}, r_rd_px} + {sh_mx[48], sh_mx});
        t_ny    = sat32({{18{r_rd_py[31]}}, r_rd_py} + {sh_my[48], sh_my});
        t_nz    = sat32({{18{r_rd_pz[31]}}, r_rd_pz} + {sh_mz[48], sh_mz});
        diff_sz = {r_rd_bs[15], r_rd_bs} - {r_rd_es[15], r_rd_es};
        out_sz  = $signed(r_psize[34:16]) + {{3{r_rd_es[15]}}, r_rd_es};
        new_res.out_x     = r_nx;
        new_res.out_y     = r_ny;
        new_res.out_z     = r_nz;
        new_res.out_size  = out_sz[15:0];
        new_res.out_red   = r_rd_tn[31:24];
        new_res.out_green = r_rd_tn[23:16];
        new_res.out_blue  = r_rd_tn[15:8];
        new_res.out_alpha = r_palpha[23:16];
        new_res.last      = 1'b0;
    end

    always_comb begin
        o_res      = r_hold;
        o_res.last = (r_state == S_TEND);
        o_res_push = 1'b0;
        o_cmd_pop  = 1'b0;
        o_div_req.start    = (r_state == S_TLOAD) && (r_rd_ll != '0);
        o_div_req.dividend = n_life;
        o_div_req.divisor  = r_rd_lt;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = i_cmd.is_tick ? S_TSCAN : S_EMUL;
                end
            end
            S_EMUL:  n_state = S_EWR;
            S_EWR:   n_state = S_IDLE;
            S_TSCAN: begin
                if (r_alive[r_idx]) begin
                    n_state = S_TLOAD;
                end else if (last_idx) begin
                    n_state = S_TEND;
                end
            end
            S_TLOAD: begin
                if (r_rd_ll != '0) begin
                    n_state = S_TDIV;
                end else begin
                    n_state = last_idx ? S_TEND : S_TSCAN;
                end
            end
            S_TDIV: begin
                if (i_div_done) begin
                    n_state = S_TFIN;
                end
            end
            S_TFIN: begin
                // Hand the held word on before taking the new one.
                if (!r_hold_v || !i_res_full) begin
                    o_res_push = r_hold_v;
                    n_state    = last_idx ? S_TEND : S_TSCAN;
                end
            end
            S_TEND: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alive  <= '0;
            r_slot   <= IW'(POOL_DEPTH - 1);
            r_idx    <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                r_idx <= '0;
            end
            if (we_emit) begin
                r_alive[r_slot] <= 1'b1;
                r_slot <= (r_slot == '0) ? IW'(POOL_DEPTH - 1) : r_slot - 1'b1;
            end
            if (r_state == S_TLOAD && r_rd_ll == '0) begin
                r_alive[r_idx] <= 1'b0;
            end
            if ((r_state == S_TSCAN && !r_alive[r_idx])
                || (r_state == S_TLOAD && r_rd_ll == '0)
                || (r_state == S_TFIN && n_state != S_TFIN)) begin
                if (!last_idx) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            // Hold the last word until the result queue takes it.
            if (r_state == S_TFIN && n_state != S_TFIN) begin
                r_hold_v <= 1'b1;
            end else if (r_state == S_TEND && n_state == S_IDLE) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_TFIN && n_state != S_TFIN) begin
            r_hold <= new_res;
        end
        r_pvx <= $signed({1'b0, i_cfg.vel_var_x}) * r_cmd.rand_x;
        r_pvy <= $signed({1'b0, i_cfg.vel_var_y}) * r_cmd.rand_y;
        r_pvz <= $signed({1'b0, i_cfg.vel_var_z}) * r_cmd.rand_z;
        r_psz <= $signed({1'b0, i_cfg.size_spread}) * r_cmd.rand_size;
        if (r_state == S_TLOAD) begin
            r_life <= n_life;
            r_pmx  <= r_rd_vx * $signed({1'b0, r_cmd.delta_time});
            r_pmy  <= r_rd_vy * $signed({1'b0, r_cmd.delta_time});
            r_pmz  <= r_rd_vz * $signed({1'b0, r_cmd.delta_time});
        end
        if (r_state == S_TDIV && i_div_done) begin
            r_nx     <= t_nx;
            r_ny     <= t_ny;
            r_nz     <= t_nz;
            r_psize  <= diff_sz * $signed({1'b0, i_div_q});
            r_palpha <= r_rd_tn[7:0] * i_div_q;
        end
    end

    // Slot memories: one write port, one registered read port at the walk index.
    always_ff @(posedge i_clk) begin
        if (we_emit) begin
            r_mem_px[r_slot] <= r_cmd.pos_x;
            r_mem_py[r_slot] <= r_cmd.pos_y;
            r_mem_pz[r_slot] <= r_cmd.pos_z;
            r_mem_vx[r_slot] <= e_vx;
            r_mem_vy[r_slot] <= e_vy;
            r_mem_vz[r_slot] <= e_vz;
            r_mem_bs[r_slot] <= e_bs;
            r_mem_es[r_slot] <= i_cfg.size_final;
            r_mem_ll[r_slot] <= i_cfg.life_span;
            r_mem_lt[r_slot] <= i_cfg.life_span;
            r_mem_tn[r_slot] <= i_cfg.colour_rgba;
        end else if (we_tick) begin
            r_mem_px[r_idx] <= r_nx;
            r_mem_py[r_idx] <= r_ny;
            r_mem_pz[r_idx] <= r_nz;
            r_mem_ll[r_idx] <= r_life;
        end
        r_rd_px <= r_mem_px[r_idx];
        r_rd_py <= r_mem_py[r_idx];
        r_rd_pz <= r_mem_pz[r_idx];
        r_rd_vx <= r_mem_vx[r_idx];
        r_rd_vy <= r_mem_vy[r_idx];
        r_rd_vz <= r_mem_vz[r_idx];
        r_rd_bs <= r_mem_bs[r_idx];
        r_rd_es <= r_mem_es[r_idx];
        r_rd_ll <= r_mem_ll[r_idx];
        r_rd_lt <= r_mem_lt[r_idx];
        r_rd_tn <= r_mem_tn[r_idx];
    end

    `PPU_ASSERT_NOW(a_push_room, o_res_push, !i_res_full, "result pushed into full queue")
    `PPU_ASSERT_NEXT(a_slot_step, we_emit, r_slot != $past(r_slot), "slot pointer did not move")
    `PPU_ASSERT_NEXT(a_div_wait, (r_state == S_TDIV) && !i_div_done, r_state == S_TDIV,
                     "left divide wait early")
    `PPU_ASSERT_NEXT(a_end_flush, (r_state == S_TEND) && (n_state == S_IDLE), !r_hold_v,
                     "held word survived tick end")
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ppu_pkg::*;

    localparam int DEPTH     = 64;
    localparam int DRAIN_CYC = 1500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    t_cmd drive_cmd = '0;
    t_res got;

    particle_pool_update_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_opcode(drive_cmd.is_tick),
        .i_pos_x(drive_cmd.pos_x), .i_pos_y(drive_cmd.pos_y), .i_pos_z(drive_cmd.pos_z),
        .i_vel_x(drive_cmd.vel_x), .i_vel_y(drive_cmd.vel_y), .i_vel_z(drive_cmd.vel_z),
        .i_rand_x(drive_cmd.rand_x), .i_rand_y(drive_cmd.rand_y),
        .i_rand_z(drive_cmd.rand_z), .i_rand_size(drive_cmd.rand_size),
        .i_delta_time(drive_cmd.delta_time),
        .empty(empty), .pop(pop),
        .o_out_x(got.out_x), .o_out_y(got.out_y), .o_out_z(got.out_z),
        .o_out_size(got.out_size), .o_out_red(got.out_red), .o_out_green(got.out_green),
        .o_out_blue(got.out_blue), .o_out_alpha(got.out_alpha), .o_last(got.last),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register shadow and pool copy
    t_cfg regs;
    logic              alive [DEPTH];
    logic signed [31:0] px [DEPTH], py [DEPTH], pz [DEPTH];
    logic signed [31:0] vx [DEPTH], vy [DEPTH], vz [DEPTH];
    logic signed [15:0] sz_begin [DEPTH], sz_end [DEPTH];
    logic [31:0]        life_left [DEPTH], life_total [DEPTH], tint [DEPTH];
    logic [5:0]         slot_ptr;

    t_cmd cmd_q[$];
    t_res sprite_q[$];
    int   n_err = 0;
    int   n_sent = 0;
    int   send_gap = 0;
    int   pop_gap = 0;
    bit   word_in, word_out;

    function automatic void enqueue(t_cmd c);
        cmd_q = {cmd_q, c};
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    function automatic logic signed [31:0] jitter(logic signed [31:0] base,
                                                  logic [30:0] spread,
                                                  logic signed [15:0] rnd);
        longint prod;
        prod = longint'(spread) * longint'(rnd);
        return 32'(clamp(longint'(base) + (prod >>> 15), -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic logic signed [31:0] move(logic signed [31:0] p,
                                                logic signed [31:0] v, logic [15:0] dt);
        longint prod;
        prod = longint'(v) * longint'(dt);
        return 32'(clamp(longint'(p) + (prod >>> 16), -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic void update_pool(t_cmd c);
        int   s;
        int   n;
        longint ratio, sz, prod;
        t_res r;
        t_res batch[$];
        if (c.is_tick == OP_EMIT) begin
            s = slot_ptr;
            alive[s] = 1'b1;
            px[s] = c.pos_x; py[s] = c.pos_y; pz[s] = c.pos_z;
            vx[s] = jitter(c.vel_x, regs.vel_var_x, c.rand_x);
            vy[s] = jitter(c.vel_y, regs.vel_var_y, c.rand_y);
            vz[s] = jitter(c.vel_z, regs.vel_var_z, c.rand_z);
            prod = longint'(regs.size_spread) * longint'(c.rand_size);
            sz_begin[s] = 16'(clamp(longint'(regs.size_start) + (prod >>> 15), -32768, 32767));
            sz_end[s] = regs.size_final;
            life_left[s] = regs.life_span;
            life_total[s] = regs.life_span;
            tint[s] = regs.colour_rgba;
            slot_ptr = slot_ptr - 6'd1;
            return;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (!alive[i])
                continue;
            if (life_left[i] == 0) begin
                alive[i] = 1'b0;
                continue;
            end
            life_left[i] = (life_left[i] > c.delta_time) ? life_left[i] - c.delta_time : 0;
            px[i] = move(px[i], vx[i], c.delta_time);
            py[i] = move(py[i], vy[i], c.delta_time);
            pz[i] = move(pz[i], vz[i], c.delta_time);
            ratio = 0;
            if (life_total[i] != 0) begin
                ratio = (longint'(life_left[i]) <<< 16) / longint'(life_total[i]);
                if (ratio > 65536)
                    ratio = 65536;
            end
            sz = longint'(sz_end[i])
                 + (((longint'(sz_begin[i]) - longint'(sz_end[i])) * ratio) >>> 16);
            r.out_x = px[i]; r.out_y = py[i]; r.out_z = pz[i];
            r.out_size = sz[15:0];
            r.out_red = tint[i][31:24];
            r.out_green = tint[i][23:16];
            r.out_blue = tint[i][15:8];
            prod = (longint'(tint[i][7:0]) * ratio) >>> 16;
            r.out_alpha = prod[7:0];
            r.last = 1'b0;
            batch = {batch, r};
        end
        n = batch.size();
        if (n > 0)
            batch[n-1].last = 1'b1;
        foreach (batch[k])
            sprite_q = {sprite_q, batch[k]};
    endfunction

    // sample both handshakes and check results
    always @(posedge i_clk) begin
        word_in = i_rst_n && push && !full;
        word_out = i_rst_n && pop && !empty;
        if (word_in)
            update_pool(drive_cmd);
        if (word_out) begin
            if (sprite_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected result %p", got);
            end else begin
                t_res want;
                want = sprite_q.pop_front();
                if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                    got.out_z !== want.out_z || got.out_size !== want.out_size ||
                    got.out_red !== want.out_red || got.out_green !== want.out_green ||
                    got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
                    got.last !== want.last) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: result mismatch\n  exp %p\n  got %p", want, got);
                end
            end
        end
    end

    function automatic int draw_gap(int idx);
        // run some stretches back to back
        return ((idx % 40) < 10) ? 0 : $urandom_range(0, 14);
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !word_in) begin
            // hold until taken
        end else if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
        end else if (cmd_q.size() > 0) begin
            drive_cmd <= cmd_q.pop_front();
            push <= 1'b1;
            n_sent++;
            send_gap = draw_gap(n_sent);
        end else begin
            push <= 1'b0;
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop && !word_out) begin
            // wait for a word
        end else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            pop_gap = draw_gap(n_sent + 7);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_VEL_VAR_X:   regs.vel_var_x = val[30:0];
            REG_VEL_VAR_Y:   regs.vel_var_y = val[30:0];
            REG_VEL_VAR_Z:   regs.vel_var_z = val[30:0];
            REG_SIZE_START:  regs.size_start = val[15:0];
            REG_SIZE_SPREAD: regs.size_spread = val[14:0];
            REG_SIZE_FINAL:  regs.size_final = val[15:0];
            REG_LIFE_SPAN:   regs.life_span = val;
            REG_COLOUR_RGBA: regs.colour_rgba = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [30:0] vx_, logic [30:0] vy_, logic [30:0] vz_,
                            logic [15:0] s0, logic [14:0] ds, logic [15:0] s1,
                            logic [31:0] life, logic [31:0] rgba);
        write_reg(REG_VEL_VAR_X, {1'b0, vx_});
        write_reg(REG_VEL_VAR_Y, {1'b0, vy_});
        write_reg(REG_VEL_VAR_Z, {1'b0, vz_});
        write_reg(REG_SIZE_START, {16'h0, s0});
        write_reg(REG_SIZE_SPREAD, {17'h0, ds});
        write_reg(REG_SIZE_FINAL, {16'h0, s1});
        write_reg(REG_LIFE_SPAN, life);
        write_reg(REG_COLOUR_RGBA, rgba);
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || push || sprite_q.size() > 0)
            @(posedge i_clk);
        // a tick with no results may still be walking the pool
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic t_cmd emit_word(logic [31:0] p, logic [31:0] v, logic [15:0] r);
        t_cmd c;
        c.is_tick = OP_EMIT;
        c.pos_x = p; c.pos_y = ~p; c.pos_z = p ^ 32'h5555_aaaa;
        c.vel_x = v; c.vel_y = ~v; c.vel_z = -v;
        c.rand_x = r; c.rand_y = ~r; c.rand_z = r ^ 16'h0ff0; c.rand_size = r;
        c.delta_time = '0;
        return c;
    endfunction

    function automatic t_cmd tick_word(logic [15:0] dt);
        t_cmd c;
        c = '0;
        c.pos_x = $urandom();
        c.is_tick = OP_TICK;
        c.delta_time = dt;
        return c;
    endfunction

    function automatic t_cmd random_word(int tick_pct, bit short_dt);
        t_cmd c;
        logic [287:0] raw;
        if ($urandom_range(0, 99) < tick_pct)
            return tick_word(short_dt ? 16'($urandom_range(0, 9000)) : 16'($urandom()));
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom()};
        c = raw[$bits(t_cmd)-1:0];
        c.is_tick = OP_EMIT;
        if ($urandom_range(0, 3) != 0) begin
            // keep motion small so positions do not pin to the rails
            c.vel_x = $signed(c.vel_x) >>> 10;
            c.vel_y = $signed(c.vel_y) >>> 10;
            c.vel_z = $signed(c.vel_z) >>> 10;
        end
        return c;
    endfunction

    task automatic random_phase(int count, int tick_pct, bit short_dt);
        repeat (count) enqueue(random_word(tick_pct, short_dt));
        drain();
    endtask

    initial begin
        regs = '0;
        regs.size_start = 16'sd256;
        regs.life_span = 32'd65536;
        regs.colour_rgba = 32'hffff_ffff;
        slot_ptr = 6'(DEPTH - 1);
        foreach (alive[i]) alive[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty pool tick, extremes, overflow, life running out
        enqueue(tick_word(16'd100));
        enqueue(emit_word(32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff));
        enqueue(emit_word(32'h8000_0000, 32'h8000_0000, 16'h8000));
        enqueue(emit_word(32'h0, 32'h0001_0000, 16'h0));
        enqueue(tick_word(16'd0));
        enqueue(tick_word(16'hffff));
        enqueue(tick_word(16'd1));
        enqueue(tick_word(16'd1));
        enqueue(tick_word(16'd1));
        drain();

        // extremes of every register
        set_regs(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 16'h7fff, 15'h7fff,
                 16'h8000, 32'hffff_ffff, 32'h00ff_00ff);
        enqueue(emit_word(32'h7fff_0000, 32'h7fff_ffff, 16'h7fff));
        enqueue(emit_word(32'h8000_ffff, 32'h8000_0000, 16'h8000));
        enqueue(emit_word(32'h1234_5678, 32'h0, 16'hffff));
        enqueue(tick_word(16'hffff));
        enqueue(tick_word(16'h8000));
        drain();

        // zero life span: cleared silently on the next tick
        set_regs(31'h0, 31'h1, 31'h0, 16'h8000, 15'h0, 16'h7fff, 32'h0, 32'hff00_ff00);
        enqueue(emit_word(32'h0, 32'h0, 16'h0));
        enqueue(tick_word(16'd5));
        enqueue(tick_word(16'd5));
        drain();

        // life longer than the pool lasts: several ticks per particle
        set_regs(31'($urandom()) >> 8, 31'($urandom()) >> 8, 31'($urandom()) >> 8,
                 16'($urandom()), 15'($urandom()), 16'($urandom()),
                 32'($urandom_range(20000, 200000)), $urandom());
        random_phase(60, 15, 1'b1);

        set_regs(31'($urandom()), 31'($urandom()), 31'($urandom()),
                 16'($urandom()), 15'($urandom()), 16'($urandom()),
                 32'($urandom_range(1, 70000)), $urandom());
        random_phase(60, 30, 1'b0);

        set_regs(31'($urandom()) >> 12, 31'($urandom()) >> 12, 31'($urandom()) >> 12,
                 16'($urandom()), 15'($urandom()), 16'($urandom()),
                 32'($urandom_range(40000, 400000)), $urandom());
        random_phase(60, 20, 1'b1);

        if (n_err == 0 && sprite_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
